### sv/luoi_pkg.sv
`default_nettype none
package luoi_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DV_GO,
    ST_DV_WT,
    ST_SPD,
    ST_CAP,
    ST_DIV_GO,
    ST_DIV_WT,
    ST_YAW,
    ST_COR_INIT,
    ST_COR_RUN,
    ST_D_GO,
    ST_D_WT,
    ST_DX_GO,
    ST_DX_WT,
    ST_DY_GO,
    ST_DY_WT,
    ST_H_GO,
    ST_H_WT,
    ST_WRAP,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    CFG_SPEED_LIMIT     = 3'd0,
    CFG_ACCEL_LIMIT     = 3'd1,
    CFG_YAW_RATE_LIMIT  = 3'd2,
    CFG_MIN_TURN_RADIUS = 3'd3,
    CFG_ALLOW_REVERSE   = 3'd4,
    CFG_MAX_STEP_TIME   = 3'd5,
    CFG_INITIAL_HEADING = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  localparam logic [19:0] MinStepTime  = 20'd1049;
  localparam logic [23:0] StopSpeed    = 24'd65;
  localparam logic signed [24:0] PiQ16    = 25'sd205887;
  localparam logic signed [24:0] TwoPiQ16 = 25'sd411775;
  localparam logic signed [27:0] PiQ24     = 28'sd52707179;
  localparam logic signed [27:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [32:0] CordicGain = 33'sd652032874;
  localparam logic [4:0] CordicLast = 5'd19;

  function automatic logic signed [27:0] atan_q24(input logic [4:0] i);
    logic signed [27:0] r;
    case (i)
      5'd0: r = 28'sd13176795;
      5'd1: r = 28'sd7778716;
      5'd2: r = 28'sd4110060;
      5'd3: r = 28'sd2086331;
      5'd4: r = 28'sd1047214;
      5'd5: r = 28'sd524117;
      5'd6: r = 28'sd262123;
      5'd7: r = 28'sd131069;
      default: r = 28'sd1 <<< (5'd24 - i);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/luoi_mul.sv
`default_nettype none
module luoi_mul
  import luoi_pkg::*;
#(
  parameter int WA = 32,
  parameter int WB = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [WA-1:0]      a_i,
  input  wire logic [WB-1:0]      b_i,
  output unit_sts_t               sts_o,
  output logic      [WA+WB-1:0]   p_o
);
  localparam int CW = $clog2(WB + 1);

  logic [WA+WB-1:0] prod_q;
  logic [WA-1:0]    a_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [WA:0]      add;

  // One multiplier bit per cycle: add the multiplicand when the low bit is set, then shift.
  assign add = {1'b0, prod_q[WA+WB-1:WB]} + (prod_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(WB - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= {{WA{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_q <= {add, prod_q[WB-1:1]};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign p_o = prod_q;
endmodule
`default_nettype wire

### sv/luoi_div.sv
`default_nettype none
module luoi_div
  import luoi_pkg::*;
#(
  parameter int WN = 40,
  parameter int WD = 24
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [WN-1:0] n_i,
  input  wire logic [WD-1:0] d_i,
  output unit_sts_t          sts_o,
  output logic      [WN-1:0] q_o
);
  localparam int CW = $clog2(WN + 1);

  logic [WN-1:0] n_q;
  logic [WD-1:0] d_q, rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [WD:0]   trial, diff;
  logic          qbit;

  // Restoring division, one quotient bit per cycle; quotient bits shift into the dividend.
  assign trial = {rem_q, n_q[WN-1]};
  assign diff  = trial - {1'b0, d_q};
  assign qbit  = (trial >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(WN - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= n_i;
      d_q   <= d_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[WD-1:0] : trial[WD-1:0];
      n_q   <= {n_q[WN-2:0], qbit};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign q_o = n_q;
endmodule
`default_nettype wire

### sv/limited_unicycle_odometry_integrator.sv
`default_nettype none
// Dead-reckoning integrator for a unicycle model with speed, slew and turn-rate limits. Each
// input beat carries speed and yaw-rate commands and the elapsed time; a beat with zero elapsed
// time is absorbed without a result, any other beat yields one result beat with the new pose
// and the applied speed and yaw rate. Items are processed one at a time: a new beat is accepted
// only when idle, and a result is held until the previous result has been taken. The time is
// set mostly by the shared bit-serial multiplier (five products), the radius divider pass
// (skipped when the speed counts as stopped or the radius cap is off), the 20-iteration CORDIC
// and up to about 21 heading wrap steps. Writing the initial heading register also loads the
// current heading.
module limited_unicycle_odometry_integrator
  import luoi_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // speed_command[23:0], yaw_rate_command[47:24], elapsed_time[67:48], zero pad
  input  wire logic [71:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // position_x[47:0], position_y[95:48], heading[114:96], applied_speed[138:115],
  // applied_yaw_rate[162:139], zero pad
  output logic [167:0]      m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [23:0]  cfg_wdata_i
);
  state_e state_q, state_d;

  logic [22:0] speed_limit_q, yaw_rate_limit_q;
  logic [23:0] accel_limit_q, min_turn_radius_q;
  logic        allow_reverse_q;
  logic [20:0] max_step_time_q;
  logic signed [18:0] yaw_q;
  logic signed [47:0] pos_x_q, pos_y_q;
  logic signed [23:0] cs_q;
  logic               m_valid_q;

  logic signed [23:0] wcmd_q, vc_q, w_q;
  logic [19:0]        dt_q;
  logic [22:0]        lim_q;
  logic signed [32:0] x_q, y_q;
  logic signed [27:0] z_q;
  logic               neg_q;
  logic [4:0]         i_q;
  logic [23:0]        dmag_q;
  logic signed [24:0] ang_q;
  logic [167:0]       out_q;

  logic accept;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  // Input decode: step time and the limited speed command.
  logic signed [23:0] vcmd_in, wcmd_in;
  logic [19:0]        e_in, dt_in;
  logic [20:0]        cap;
  logic signed [24:0] vcr, vlim_s, vc_in;
  assign vcmd_in = s_axis_tdata[23:0];
  assign wcmd_in = s_axis_tdata[47:24];
  assign e_in    = s_axis_tdata[67:48];
  assign cap     = (max_step_time_q < {1'b0, MinStepTime}) ? {1'b0, MinStepTime}
                                                           : max_step_time_q;
  assign dt_in   = ({1'b0, e_in} < cap) ? e_in : cap[19:0];
  assign vcr     = (!allow_reverse_q && vcmd_in < 0) ? '0 : 25'(vcmd_in);
  assign vlim_s  = $signed({2'b0, speed_limit_q});
  always_comb begin
    vc_in = vcr;
    if (vc_in > vlim_s) vc_in = vlim_s;
    if (vc_in < -vlim_s) vc_in = -vlim_s;
  end

  // Shared serial multiplier and the serial divider.
  unit_sts_t   mul_sts, div_sts;
  logic        mul_start, div_start;
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] mul_p;
  logic [39:0] div_q;
  logic [23:0] vabs;
  logic [32:0] cabs, sabs;
  logic        cneg, sneg;

  assign vabs = cs_q[23] ? 24'(-cs_q) : 24'(cs_q);
  assign cabs = x_q[32] ? 33'(-x_q) : 33'(x_q);
  assign sabs = y_q[32] ? 33'(-y_q) : 33'(y_q);
  assign cneg = neg_q ^ x_q[32];
  assign sneg = neg_q ^ y_q[32];

  always_comb begin
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_DV_GO: begin
        mul_start = 1'b1;
        mul_a = {8'b0, accel_limit_q};
        mul_b = {4'b0, dt_q};
      end
      ST_D_GO: begin
        mul_start = 1'b1;
        mul_a = {8'b0, vabs};
        mul_b = {4'b0, dt_q};
      end
      ST_DX_GO: begin
        mul_start = 1'b1;
        mul_a = cabs[31:0];
        mul_b = dmag_q;
      end
      ST_DY_GO: begin
        mul_start = 1'b1;
        mul_a = sabs[31:0];
        mul_b = dmag_q;
      end
      ST_H_GO: begin
        mul_start = 1'b1;
        mul_a = {8'b0, (w_q[23] ? 24'(-w_q) : 24'(w_q))};
        mul_b = {4'b0, dt_q};
      end
      default: ;
    endcase
  end
  assign div_start = (state_q == ST_DIV_GO);

  luoi_mul #(.WA(32), .WB(24)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .sts_o(mul_sts), .p_o(mul_p)
  );

  luoi_div #(.WN(40), .WD(24)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .n_i({vabs, 16'b0}), .d_i(min_turn_radius_q),
    .sts_o(div_sts), .q_o(div_q)
  );

  // Speed slew.
  logic signed [25:0] vnew;
  logic [23:0] dv_q;
  logic signed [25:0] slo, shi;
  assign slo = 26'(cs_q) - $signed({2'b0, dv_q});
  assign shi = 26'(cs_q) + $signed({2'b0, dv_q});
  always_comb begin
    vnew = 26'(vc_q);
    if (vnew > shi) vnew = shi;
    if (vnew < slo) vnew = slo;
  end

  // Yaw-rate clamp.
  logic signed [24:0] lim_s, wcl;
  assign lim_s = $signed({2'b0, lim_q});
  always_comb begin
    wcl = 25'(wcmd_q);
    if (wcl > lim_s) wcl = lim_s;
    if (wcl < -lim_s) wcl = -lim_s;
  end

  // CORDIC step.
  logic signed [27:0] z_init, zf;
  logic               fneg;
  logic signed [32:0] xs, ys;
  logic signed [27:0] at;
  assign z_init = 28'(yaw_q) <<< 8;
  always_comb begin
    zf = z_init;
    fneg = 1'b0;
    if (z_init > HalfPiQ24) begin
      zf = z_init - PiQ24;
      fneg = 1'b1;
    end else if (z_init < -HalfPiQ24) begin
      zf = z_init + PiQ24;
      fneg = 1'b1;
    end
  end
  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = atan_q24(i_q);

  // Position update terms.
  logic [25:0]        dpmag;
  logic signed [47:0] dpos;
  logic               dneg;
  assign dneg  = cs_q[23];
  assign dpmag = mul_p[55:30];
  assign dpos  = $signed({22'b0, dpmag});

  logic signed [24:0] hstep;
  assign hstep = $signed({1'b0, mul_p[43:20]});

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (accept && e_in != '0) state_d = ST_DV_GO;
      ST_DV_GO:    state_d = ST_DV_WT;
      ST_DV_WT:    if (mul_sts.done) state_d = ST_SPD;
      ST_SPD:      state_d = ST_CAP;
      ST_CAP: begin
        if (vabs <= StopSpeed) state_d = ST_COR_INIT;
        else if (min_turn_radius_q == '0) state_d = ST_YAW;
        else state_d = ST_DIV_GO;
      end
      ST_DIV_GO:   state_d = ST_DIV_WT;
      ST_DIV_WT:   if (div_sts.done) state_d = ST_YAW;
      ST_YAW:      state_d = ST_COR_INIT;
      ST_COR_INIT: state_d = ST_COR_RUN;
      ST_COR_RUN:  if (i_q == CordicLast) state_d = ST_D_GO;
      ST_D_GO:     state_d = ST_D_WT;
      ST_D_WT:     if (mul_sts.done) state_d = ST_DX_GO;
      ST_DX_GO:    state_d = ST_DX_WT;
      ST_DX_WT:    if (mul_sts.done) state_d = ST_DY_GO;
      ST_DY_GO:    state_d = ST_DY_WT;
      ST_DY_WT:    if (mul_sts.done) state_d = ST_H_GO;
      ST_H_GO:     state_d = ST_H_WT;
      ST_H_WT:     if (mul_sts.done) state_d = ST_WRAP;
      ST_WRAP: begin
        if (!(ang_q > PiQ16) && !(ang_q < -PiQ16)) state_d = ST_OUT;
      end
      ST_OUT:      if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      speed_limit_q     <= 23'd234378;
      accel_limit_q     <= 24'd98304;
      yaw_rate_limit_q  <= 23'd131072;
      min_turn_radius_q <= 24'd117965;
      allow_reverse_q   <= 1'b0;
      max_step_time_q   <= 21'd52429;
      yaw_q             <= '0;
      pos_x_q           <= '0;
      pos_y_q           <= '0;
      cs_q              <= '0;
      m_valid_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SPEED_LIMIT:     speed_limit_q     <= cfg_wdata_i[22:0];
          CFG_ACCEL_LIMIT:     accel_limit_q     <= cfg_wdata_i;
          CFG_YAW_RATE_LIMIT:  yaw_rate_limit_q  <= cfg_wdata_i[22:0];
          CFG_MIN_TURN_RADIUS: min_turn_radius_q <= cfg_wdata_i;
          CFG_ALLOW_REVERSE:   allow_reverse_q   <= cfg_wdata_i[0];
          CFG_MAX_STEP_TIME:   max_step_time_q   <= cfg_wdata_i[20:0];
          CFG_INITIAL_HEADING: yaw_q             <= cfg_wdata_i[18:0];
          default: ;
        endcase
      end
      if (state_q == ST_SPD) cs_q <= vnew[23:0];
      if (state_q == ST_DX_WT && mul_sts.done)
        pos_x_q <= (dneg ^ cneg) ? pos_x_q - dpos : pos_x_q + dpos;
      if (state_q == ST_DY_WT && mul_sts.done)
        pos_y_q <= (dneg ^ sneg) ? pos_y_q - dpos : pos_y_q + dpos;
      if (state_q == ST_WRAP && state_d == ST_OUT) yaw_q <= ang_q[18:0];
      if (state_q == ST_OUT && state_d == ST_IDLE) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wcmd_q <= wcmd_in;
      dt_q   <= dt_in;
      vc_q   <= vc_in[23:0];
    end
    if (state_q == ST_DV_WT && mul_sts.done) dv_q <= mul_p[43:20];
    if (state_q == ST_CAP) begin
      w_q   <= '0;
      lim_q <= yaw_rate_limit_q;
    end
    if (state_q == ST_DIV_WT && div_sts.done && div_q < {17'b0, yaw_rate_limit_q})
      lim_q <= div_q[22:0];
    if (state_q == ST_YAW) w_q <= wcl[23:0];
    if (state_q == ST_COR_INIT) begin
      z_q   <= zf;
      neg_q <= fneg;
      x_q   <= CordicGain;
      y_q   <= '0;
      i_q   <= '0;
    end
    if (state_q == ST_COR_RUN) begin
      i_q <= i_q + 1'b1;
      if (!z_q[27]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
    if (state_q == ST_D_WT && mul_sts.done) dmag_q <= mul_p[43:20];
    if (state_q == ST_H_WT && mul_sts.done)
      ang_q <= w_q[23] ? 25'(yaw_q) - hstep : 25'(yaw_q) + hstep;
    if (state_q == ST_WRAP) begin
      if (ang_q > PiQ16) ang_q <= ang_q - TwoPiQ16;
      else if (ang_q < -PiQ16) ang_q <= ang_q + TwoPiQ16;
    end
    if (state_q == ST_OUT && state_d == ST_IDLE)
      out_q <= {5'b0, w_q, cs_q, yaw_q, pos_y_q, pos_x_q};
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
endmodule
`default_nettype wire

### sim/odometry_checker.sv
module odometry_checker
  import luoi_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  logic [71:0]  in_data_i,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic [167:0] out_data_i,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [23:0]  cfg_wdata_i,
  output int           fail_count_o,
  output int           pending_o
);

  // Members run from the highest bits down, matching the result beat layout.
  typedef struct packed {
    logic signed [23:0] rate;
    logic signed [23:0] spd;
    logic signed [18:0] hdg;
    logic signed [47:0] py;
    logic signed [47:0] px;
  } pose_t;

  longint speed_lim, accel_lim, rate_lim, radius, reverse_ok, step_max, heading_preset;
  longint pos_x, pos_y, yaw, speed;
  pose_t  pose_q[$];

  function automatic longint floor_shift(longint v, int s);
    return (v >= 0) ? (v >>> s) : -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint zero_shift(longint v, int s);
    return (v >= 0) ? (v >>> s) : -((-v) >>> s);
  endfunction

  function automatic longint bound(longint v, longint lo, longint hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[8] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069};
    return (i < 8) ? tbl[i] : (longint'(1) << (24 - i));
  endfunction

  task automatic rotate(input longint ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = ang * 256;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 26353589) begin
      z -= 52707179;
      flip = 1;
    end else if (z < -26353589) begin
      z += 52707179;
      flip = 1;
    end
    for (int i = 0; i < 20; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= atan_step(i);
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += atan_step(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic advance_pose(input logic [71:0] d);
    longint vcmd, wcmd, el, dt, cap, dv, vabs, w, c, s, travel, lim, q;
    pose_t p;
    vcmd = longint'($signed(d[23:0]));
    wcmd = longint'($signed(d[47:24]));
    el = longint'(d[67:48]);
    if (el == 0) return;
    cap = (step_max < 1049) ? 1049 : step_max;
    dt = (el < cap) ? el : cap;
    if (reverse_ok == 0 && vcmd < 0) vcmd = 0;
    vcmd = bound(vcmd, -speed_lim, speed_lim);
    dv = (accel_lim * dt) >>> 20;
    speed = bound(vcmd, speed - dv, speed + dv);
    vabs = (speed < 0) ? -speed : speed;
    if (vabs * 1000 <= 65536) w = 0;
    else begin
      lim = rate_lim;
      if (radius != 0) begin
        q = (vabs * 65536) / radius;
        if (q < lim) lim = q;
      end
      w = bound(wcmd, -lim, lim);
    end
    rotate(yaw, c, s);
    travel = zero_shift(speed * dt, 20);
    pos_x = longint'($signed(48'(pos_x + zero_shift(travel * c, 30))));
    pos_y = longint'($signed(48'(pos_y + zero_shift(travel * s, 30))));
    yaw = yaw + zero_shift(w * dt, 20);
    if (yaw > 205887) yaw -= ((yaw - 205887 + 411774) / 411775) * 411775;
    else if (yaw < -205887) yaw += ((-205887 - yaw + 411774) / 411775) * 411775;
    p.px = 48'(pos_x);
    p.py = 48'(pos_y);
    p.hdg = 19'(yaw);
    p.spd = 24'(speed);
    p.rate = 24'(w);
    pose_q.push_back(p);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count_o++;
  endtask

  assign pending_o = pose_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t got, want;
    if (!rst_ni) begin
      speed_lim = 234378;
      accel_lim = 98304;
      rate_lim = 131072;
      radius = 117965;
      reverse_ok = 0;
      step_max = 52429;
      heading_preset = 0;
      pos_x = 0;
      pos_y = 0;
      yaw = 0;
      speed = 0;
      pose_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_data_i[162:0];
        if (pose_q.size() == 0) report("unexpected beat", 0, 0);
        else begin
          want = pose_q.pop_front();
          if (got.px != want.px)
            report("position_x", longint'(got.px), longint'(want.px));
          if (got.py != want.py)
            report("position_y", longint'(got.py), longint'(want.py));
          if (got.hdg != want.hdg)
            report("heading", longint'(got.hdg), longint'(want.hdg));
          if (got.spd != want.spd)
            report("applied_speed", longint'(got.spd), longint'(want.spd));
          if (got.rate != want.rate)
            report("applied_yaw_rate", longint'(got.rate), longint'(want.rate));
        end
      end
      if (in_valid_i && in_ready_i) advance_pose(in_data_i);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SPEED_LIMIT:     speed_lim = longint'(cfg_wdata_i[22:0]);
          CFG_ACCEL_LIMIT:     accel_lim = longint'(cfg_wdata_i);
          CFG_YAW_RATE_LIMIT:  rate_lim = longint'(cfg_wdata_i[22:0]);
          CFG_MIN_TURN_RADIUS: radius = longint'(cfg_wdata_i);
          CFG_ALLOW_REVERSE:   reverse_ok = longint'(cfg_wdata_i[0]);
          CFG_MAX_STEP_TIME:   step_max = longint'(cfg_wdata_i[20:0]);
          CFG_INITIAL_HEADING: begin
            heading_preset = longint'($signed(cfg_wdata_i[18:0]));
            yaw = heading_preset;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

### sim/tb.sv
module tb;
  import luoi_pkg::*;

  // An index that no register answers to.
  localparam logic [2:0] UnusedReg = 3'd7;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [167:0] m_axis_tdata;
  logic         cfg_we_i = 0;
  logic [2:0]   cfg_idx_i = '0;
  logic [23:0]  cfg_wdata_i = '0;
  int           fail_count, pending;
  int           send_idle, recv_idle;
  longint       cycles = 0;

  always #1 clk_i = ~clk_i;

  limited_unicycle_odometry_integrator u_dut (.*);

  odometry_checker u_chk (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_i(s_axis_tready), .in_data_i(s_axis_tdata),
    .out_valid_i(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_i(m_axis_tdata),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("** limited_unicycle_odometry_integrator: FAILED **");
      $finish;
    end
  end

  // Receiver stalls at random, changing only on the falling edge.
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_idle);

  task automatic send_tick(input int spd, input int rate, input int el);
    while ($urandom_range(99) < send_idle) @(negedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'b0, 20'(el), 24'(rate), 24'(spd)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid <= 0;
    @(negedge clk_i);
  endtask

  // Zero-time ticks produce nothing, so allow the last one to drain as well.
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= 24'(val);
    @(negedge clk_i);
    cfg_we_i <= 0;
    @(negedge clk_i);
  endtask

  task automatic random_ticks(input int n);
    int spd, el, r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      spd = (r < 80) ? $urandom_range(400000) - 200000 : $urandom;
      el = (r < 5) ? 0 : (r < 85) ? $urandom_range(60000, 1) : $urandom_range(1048575);
      send_tick(spd, (r < 70) ? $urandom_range(300000) - 150000 : $urandom, el);
      if ($urandom_range(199) == 0) drain();
    end
  endtask

  initial begin
    send_idle = 0;
    recv_idle = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: field extremes, skip, reverse handling, overflow-prone heading.
    send_tick(8388607, 8388607, 1048575);
    send_tick(-8388608, -8388608, 1);
    send_tick(100000, 50000, 0);
    send_tick(200000, 100000, 30000);
    send_tick(-200000, -100000, 30000);
    send_tick(0, 0, 20);
    drain();
    write_reg(CFG_ALLOW_REVERSE, 1);
    write_reg(CFG_INITIAL_HEADING, -262144);
    write_reg(CFG_MIN_TURN_RADIUS, 16777215);
    write_reg(UnusedReg, 12345);
    send_tick(-8388608, 8388607, 1048575);
    send_tick(-65, 1000, 1000);
    send_tick(8388607, -8388608, 1048575);
    drain();
    write_reg(CFG_SPEED_LIMIT, 8388607);
    write_reg(CFG_ACCEL_LIMIT, 16777215);
    write_reg(CFG_YAW_RATE_LIMIT, 8388607);
    write_reg(CFG_MIN_TURN_RADIUS, 0);
    write_reg(CFG_MAX_STEP_TIME, 1048576);
    write_reg(CFG_INITIAL_HEADING, 262143);
    for (int i = 0; i < 6; i++) send_tick(8388607, 8388607, 1048575);
    send_tick(-8388608, -8388608, 1048575);
    drain();

    send_idle = 35;
    recv_idle = 57;
    write_reg(CFG_MAX_STEP_TIME, 0);
    write_reg(CFG_ACCEL_LIMIT, 0);
    random_ticks(150);
    drain();
    write_reg(CFG_ACCEL_LIMIT, 5000000);
    write_reg(CFG_SPEED_LIMIT, 0);
    write_reg(CFG_YAW_RATE_LIMIT, 0);
    random_ticks(50);

    drain();
    send_idle = 57;
    recv_idle = 35;
    write_reg(CFG_SPEED_LIMIT, 500000);
    write_reg(CFG_YAW_RATE_LIMIT, 300000);
    write_reg(CFG_MIN_TURN_RADIUS, 65536);
    write_reg(CFG_MAX_STEP_TIME, 100000);
    write_reg(CFG_ALLOW_REVERSE, 0);
    write_reg(CFG_INITIAL_HEADING, -205887);
    random_ticks(300);

    drain();
    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_ALLOW_REVERSE, 1);
    write_reg(CFG_ACCEL_LIMIT, 16777215);
    write_reg(CFG_MIN_TURN_RADIUS, 1);
    write_reg(CFG_INITIAL_HEADING, 205887);
    random_ticks(330);
    drain();

    if (fail_count == 0) begin
      $display("** limited_unicycle_odometry_integrator: PASSED **");
    end else begin
      $display("** limited_unicycle_odometry_integrator: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
sv/luoi_pkg.sv
sv/luoi_mul.sv
sv/luoi_div.sv
sv/limited_unicycle_odometry_integrator.sv
sim/odometry_checker.sv
sim/tb.sv
